>>> sv/ps2h_pkg.sv
`timescale 1ns / 1ps

package ps2h_pkg;

    // Request opcodes
    localparam logic [1:0] OP_EDGE = 2'd0;
    localparam logic [1:0] OP_TX   = 2'd1;
    localparam logic [1:0] OP_POP  = 2'd2;

    // Event codes reported with each result
    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_QUEUED   = 3'd1;
    localparam logic [2:0] EV_ACK      = 3'd2;
    localparam logic [2:0] EV_ACK_BAD  = 3'd3;
    localparam logic [2:0] EV_PAR_ERR  = 3'd4;
    localparam logic [2:0] EV_FRM_ERR  = 3'd5;
    localparam logic [2:0] EV_TX_DONE  = 3'd6;

    // Acknowledge status codes
    localparam logic [1:0] ACK_NONE = 2'd0;
    localparam logic [1:0] ACK_OK   = 2'd1;
    localparam logic [1:0] ACK_BAD  = 2'd2;

    localparam logic [7:0] ACK_BYTE = 8'hFA;

    // Bit positions within a frame (0 start, 1..8 data, 9 parity, 10 stop)
    localparam logic [3:0] IDX_START    = 4'd0;
    localparam logic [3:0] IDX_LAST_DAT = 4'd8;
    localparam logic [3:0] IDX_PARITY   = 4'd9;
    localparam logic [3:0] IDX_STOP     = 4'd10;

    typedef struct packed {
        logic       drive_data_low;
        logic       release_lines;
        logic       inhibit_clock;
        logic [2:0] event_res;
        logic [7:0] popped_byte;
        logic       overflow_flag;
        logic [1:0] ack_status;
        logic [7:0] parity_error_count;
        logic [7:0] framing_error_count;
        logic       transmitting;
        logic       resend_request;
    } t_result;

    typedef struct packed {
        logic       push;
        logic [7:0] push_data;
        logic       pop;
    } t_fifo_ctrl;

    typedef struct packed {
        logic       full;
        logic       head_valid;
        logic [7:0] head_data;
    } t_fifo_status;

endpackage

>>> sv/ps2h_rx_fifo.sv
`timescale 1ns / 1ps

module ps2h_rx_fifo
    import ps2h_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_fifo_ctrl   i_ctrl,
    output t_fifo_status o_status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [7:0]      mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [7:0]      r_rd_data;

    function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
        return (p == LAST) ? '0 : p + AW'(1);
    endfunction

    always_comb begin
        n_wr_ptr = i_ctrl.push ? bump(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_ctrl.pop  ? bump(r_rd_ptr) : r_rd_ptr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (i_ctrl.push) begin
                r_valid[r_wr_ptr] <= 1'b1;
            end
            if (i_ctrl.pop) begin
                r_valid[r_rd_ptr] <= 1'b0;
            end
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
        end
    end

    // The read port follows the head pointer; a write to the new head is
    // forwarded so the read register always mirrors the head entry.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            mem[r_wr_ptr] <= i_ctrl.push_data;
        end
        if (i_ctrl.push && (r_wr_ptr == n_rd_ptr)) begin
            r_rd_data <= i_ctrl.push_data;
        end else begin
            r_rd_data <= mem[n_rd_ptr];
        end
    end

    assign o_status.full       = r_valid[r_wr_ptr];
    assign o_status.head_valid = r_valid[r_rd_ptr];
    assign o_status.head_data  = r_rd_data;

endmodule

>>> sv/ps2h_core.sv
`timescale 1ns / 1ps

module ps2h_core
    import ps2h_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_fire,
    input  logic [1:0]   i_opcode,
    input  logic         i_data_line,
    input  logic [7:0]   i_tx_byte,
    input  t_fifo_status i_fifo,
    output t_fifo_ctrl   o_fifo,
    output t_result      o_result
);

    logic       r_tx_mode,    n_tx_mode;
    logic [3:0] r_tx_idx,     n_tx_idx;
    logic [7:0] r_tx_shift,   n_tx_shift;
    logic       r_tx_parity,  n_tx_parity;
    logic [3:0] r_rx_idx,     n_rx_idx;
    logic [7:0] r_rx_shift,   n_rx_shift;
    logic [2:0] r_frame_bits, n_frame_bits;
    logic       r_expect_ack, n_expect_ack;
    logic [1:0] r_ack_state,  n_ack_state;
    logic       r_overflow,   n_overflow;
    logic [7:0] r_par_errs,   n_par_errs;
    logic [7:0] r_frm_errs,   n_frm_errs;
    logic       r_resend,     n_resend;

    logic       release_l;
    logic       inhibit;
    logic [2:0] ev;
    logic [7:0] popped;
    logic       ovf_out;
    logic       rs_out;
    logic       drive;
    logic       push;
    logic       pop;

    always_comb begin
        n_tx_mode    = r_tx_mode;
        n_tx_idx     = r_tx_idx;
        n_tx_shift   = r_tx_shift;
        n_tx_parity  = r_tx_parity;
        n_rx_idx     = r_rx_idx;
        n_rx_shift   = r_rx_shift;
        n_frame_bits = r_frame_bits;
        n_expect_ack = r_expect_ack;
        n_ack_state  = r_ack_state;
        n_overflow   = r_overflow;
        n_par_errs   = r_par_errs;
        n_frm_errs   = r_frm_errs;
        n_resend     = r_resend;
        release_l    = 1'b0;
        inhibit      = 1'b0;
        ev           = EV_NONE;
        popped       = 8'd0;
        push         = 1'b0;
        pop          = 1'b0;

        unique case (i_opcode)
            OP_EDGE: begin
                if (r_tx_mode) begin
                    if (r_tx_idx < IDX_STOP) begin
                        n_tx_idx = r_tx_idx + 4'd1;
                    end else begin
                        n_tx_idx     = IDX_START;
                        n_tx_mode    = 1'b0;
                        release_l    = 1'b1;
                        n_rx_idx     = IDX_START;
                        n_rx_shift   = 8'd0;
                        n_frame_bits = 3'd0;
                        n_expect_ack = 1'b1;
                        ev           = EV_TX_DONE;
                    end
                end else if (r_rx_idx == IDX_START) begin
                    n_frame_bits = {2'b00, i_data_line};
                    n_rx_idx     = r_rx_idx + 4'd1;
                end else if (r_rx_idx <= IDX_LAST_DAT) begin
                    n_rx_shift = r_rx_shift | (8'(i_data_line) << (r_rx_idx - 4'd1));
                    n_rx_idx   = r_rx_idx + 4'd1;
                end else if (r_rx_idx == IDX_PARITY) begin
                    n_frame_bits = {i_data_line, r_frame_bits[1:0]};
                    n_rx_idx     = r_rx_idx + 4'd1;
                end else begin
                    // Stop bit: check the whole frame and then start afresh.
                    if (r_frame_bits[0] || !i_data_line) begin
                        n_frm_errs = r_frm_errs + 8'd1;
                        ev         = EV_FRM_ERR;
                    end else if ((^r_rx_shift ^ r_frame_bits[2]) == 1'b0) begin
                        if (r_expect_ack) begin
                            n_ack_state = ACK_BAD;
                            ev          = EV_ACK_BAD;
                        end else begin
                            n_par_errs = r_par_errs + 8'd1;
                            n_resend   = 1'b1;
                            inhibit    = 1'b1;
                            ev         = EV_PAR_ERR;
                        end
                    end else if (r_rx_shift == ACK_BYTE) begin
                        n_ack_state = ACK_OK;
                        ev          = EV_ACK;
                    end else if (i_fifo.full) begin
                        n_overflow = 1'b1;
                    end else if (r_rx_shift != 8'd0) begin
                        push = 1'b1;
                        ev   = EV_QUEUED;
                    end
                    n_rx_idx     = IDX_START;
                    n_rx_shift   = 8'd0;
                    n_frame_bits = 3'd0;
                    n_expect_ack = 1'b0;
                end
            end
            OP_TX: begin
                n_tx_mode   = 1'b1;
                n_tx_idx    = IDX_START;
                n_tx_shift  = i_tx_byte;
                n_tx_parity = ~^i_tx_byte;
                n_ack_state = ACK_NONE;
            end
            OP_POP: begin
                if (i_fifo.head_valid) begin
                    popped = i_fifo.head_data;
                    pop    = 1'b1;
                end
                n_overflow = 1'b0;
                n_resend   = 1'b0;
            end
            default: begin
            end
        endcase

        // A pop reports the sticky flags as they stood before it cleared them.
        ovf_out = (i_opcode == OP_POP) ? r_overflow : n_overflow;
        rs_out  = (i_opcode == OP_POP) ? r_resend   : n_resend;

        if (!n_tx_mode) begin
            drive = 1'b0;
        end else if (n_tx_idx == IDX_START) begin
            drive = 1'b1;
        end else if (n_tx_idx <= IDX_LAST_DAT) begin
            drive = ~n_tx_shift[3'(n_tx_idx - 4'd1)];
        end else if (n_tx_idx == IDX_PARITY) begin
            drive = ~n_tx_parity;
        end else begin
            drive = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_mode    <= 1'b0;
            r_tx_idx     <= '0;
            r_tx_shift   <= '0;
            r_tx_parity  <= 1'b0;
            r_rx_idx     <= '0;
            r_rx_shift   <= '0;
            r_frame_bits <= '0;
            r_expect_ack <= 1'b0;
            r_ack_state  <= ACK_NONE;
            r_overflow   <= 1'b0;
            r_par_errs   <= '0;
            r_frm_errs   <= '0;
            r_resend     <= 1'b0;
        end else if (i_fire) begin
            r_tx_mode    <= n_tx_mode;
            r_tx_idx     <= n_tx_idx;
            r_tx_shift   <= n_tx_shift;
            r_tx_parity  <= n_tx_parity;
            r_rx_idx     <= n_rx_idx;
            r_rx_shift   <= n_rx_shift;
            r_frame_bits <= n_frame_bits;
            r_expect_ack <= n_expect_ack;
            r_ack_state  <= n_ack_state;
            r_overflow   <= n_overflow;
            r_par_errs   <= n_par_errs;
            r_frm_errs   <= n_frm_errs;
            r_resend     <= n_resend;
        end
    end

    assign o_fifo.push      = i_fire & push;
    assign o_fifo.push_data = r_rx_shift;
    assign o_fifo.pop       = i_fire & pop;

    assign o_result.drive_data_low      = drive;
    assign o_result.release_lines       = release_l;
    assign o_result.inhibit_clock       = inhibit;
    assign o_result.event_res           = ev;
    assign o_result.popped_byte         = popped;
    assign o_result.overflow_flag       = ovf_out;
    assign o_result.ack_status          = n_ack_state;
    assign o_result.parity_error_count  = n_par_errs;
    assign o_result.framing_error_count = n_frm_errs;
    assign o_result.transmitting        = n_tx_mode;
    assign o_result.resend_request      = rs_out;

endmodule

>>> sv/ps2_host_frame_engine.sv
`timescale 1ns / 1ps
// PS/2 host frame engine.
// Requests enter on the input channel (i_valid / o_ready) with an opcode:
// a falling edge of the device clock with the sampled data line, a start of
// transmit with the command byte, or a pop of the receive buffer. Every
// request yields exactly one result on the output channel (o_valid /
// i_ready) carrying the line controls, the event code, the popped byte and
// the status counters and flags as they stand after that request; a pop
// reports the sticky flags as they stood before it cleared them.
// A taken request is registered in the input register, processed once the
// output register is free or being emptied, and its result is registered
// in the output register until taken. Throughput is one request per cycle
// while i_ready stays high; the receive buffer read port tracks its head
// pointer so pops never wait.
// When the receiver stalls, the output register holds its result and the
// input register still takes one more request; o_ready drops only once both
// are full, and it rises in the same cycle that i_ready frees the output.
// Synchronous reset (i_rst_n low) empties both registers, returns the engine
// to receiving, clears all counters and flags and marks every receive
// buffer entry empty at once; requests are accepted right after reset.

module ps2_host_frame_engine
    import ps2h_pkg::*;
#(
    parameter int FIFO_DEPTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,

    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_opcode,
    input  logic       i_data_line,
    input  logic [7:0] i_tx_byte,

    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_drive_data_low,
    output logic       o_release_lines,
    output logic       o_inhibit_clock,
    output logic [2:0] o_event_res,
    output logic [7:0] o_popped_byte,
    output logic       o_overflow_flag,
    output logic [1:0] o_ack_status,
    output logic [7:0] o_parity_error_count,
    output logic [7:0] o_framing_error_count,
    output logic       o_transmitting,
    output logic       o_resend_request
);

    // Input register
    logic       r_in_valid;
    logic [1:0] r_in_opcode;
    logic       r_in_data_line;
    logic [7:0] r_in_tx_byte;

    // Output register
    logic       r_out_valid;
    t_result    r_out;

    logic         fire;
    logic         take;
    t_result      result;
    t_fifo_ctrl   fifo_ctrl;
    t_fifo_status fifo_status;

    // A held request is processed whenever the output register is free or
    // is being emptied in this cycle.
    assign fire    = r_in_valid & (~r_out_valid | i_ready);
    assign o_ready = ~r_in_valid | fire;
    assign take    = i_valid & o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in_opcode    <= i_opcode;
            r_in_data_line <= i_data_line;
            r_in_tx_byte   <= i_tx_byte;
        end
    end

    ps2h_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_opcode    (r_in_opcode),
        .i_data_line (r_in_data_line),
        .i_tx_byte   (r_in_tx_byte),
        .i_fifo      (fifo_status),
        .o_fifo      (fifo_ctrl),
        .o_result    (result)
    );

    ps2h_rx_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_rx_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (fifo_ctrl),
        .o_status (fifo_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= result;
        end
    end

    assign o_valid               = r_out_valid;
    assign o_drive_data_low      = r_out.drive_data_low;
    assign o_release_lines       = r_out.release_lines;
    assign o_inhibit_clock       = r_out.inhibit_clock;
    assign o_event_res           = r_out.event_res;
    assign o_popped_byte         = r_out.popped_byte;
    assign o_overflow_flag       = r_out.overflow_flag;
    assign o_ack_status          = r_out.ack_status;
    assign o_parity_error_count  = r_out.parity_error_count;
    assign o_framing_error_count = r_out.framing_error_count;
    assign o_transmitting        = r_out.transmitting;
    assign o_resend_request      = r_out.resend_request;

endmodule

>>> sim/tb_ps2_host_frame_engine.sv
`timescale 1ns / 1ps

// Self-checking bench for the PS/2 host frame engine.
//
// Requests are queued by the stimulus process and fed to the block by a
// clocked driver that honors the valid/ready handshake. Each accepted request
// runs through a shadow model of the engine, and the model's result goes to
// the back of a queue. A clocked monitor takes each result the block hands
// over and compares it, field by field, with the oldest entry in that queue.
//
// The stimulus keeps the device-side frames aligned. Noise bursts and partial
// frames are always followed by a complete transmit frame, because the edge
// that ends a transmit clears any partial receive.

module tb_ps2_host_frame_engine;
    import ps2h_pkg::*;

    localparam int         CLK_PERIOD   = 8;
    localparam int         FIFO_DEPTH   = 32;
    localparam int         FRAME_EDGES  = 11;    // start, 8 data, parity, stop
    localparam int         QUIET_LIMIT  = 4000;  // cycles with no handshake at all
    localparam int         SETTLE_WAIT  = 10;    // idle wait before the final check
    localparam int         PHASE_ITEMS  = 240;
    localparam int         NUM_PHASES   = 5;
    localparam logic [1:0] OP_UNUSED    = 2'd3;

    typedef struct packed {
        logic [1:0] opcode;
        logic       data_line;
        logic [7:0] tx_data;
    } t_request;

    // ------------------------------------------------------------------
    // Block inputs. All of them start at a known level.
    // ------------------------------------------------------------------
    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic [1:0] i_opcode    = OP_EDGE;
    logic       i_data_line = 1'b0;
    logic [7:0] i_tx_byte   = 8'h00;
    logic       i_ready     = 1'b0;

    logic       o_ready;
    logic       o_valid;
    logic       o_drive_data_low;
    logic       o_release_lines;
    logic       o_inhibit_clock;
    logic [2:0] o_event_res;
    logic [7:0] o_popped_byte;
    logic       o_overflow_flag;
    logic [1:0] o_ack_status;
    logic [7:0] o_parity_error_count;
    logic [7:0] o_framing_error_count;
    logic       o_transmitting;
    logic       o_resend_request;

    ps2_host_frame_engine u_top (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_valid               (i_valid),
        .o_ready               (o_ready),
        .i_opcode              (i_opcode),
        .i_data_line           (i_data_line),
        .i_tx_byte             (i_tx_byte),
        .o_valid               (o_valid),
        .i_ready               (i_ready),
        .o_drive_data_low      (o_drive_data_low),
        .o_release_lines       (o_release_lines),
        .o_inhibit_clock       (o_inhibit_clock),
        .o_event_res           (o_event_res),
        .o_popped_byte         (o_popped_byte),
        .o_overflow_flag       (o_overflow_flag),
        .o_ack_status          (o_ack_status),
        .o_parity_error_count  (o_parity_error_count),
        .o_framing_error_count (o_framing_error_count),
        .o_transmitting        (o_transmitting),
        .o_resend_request      (o_resend_request)
    );

    // ------------------------------------------------------------------
    // Bench bookkeeping.
    // ------------------------------------------------------------------
    t_request pending_requests[$];
    t_result  expected_results[$];
    int       items_queued  = 0;
    int       results_seen  = 0;
    int       mismatches    = 0;
    int       quiet_cycles  = 0;
    int       send_idle_pct = 0;  // chance that the driver skips a cycle
    int       stall_pct     = 0;  // chance that the receiver holds off
    int       pop_mix       = 0;  // chance of a pop slipped into a frame

    // ------------------------------------------------------------------
    // Shadow copy of the engine state. Its initial values are the reset
    // values, since reset is applied once, at time zero.
    // ------------------------------------------------------------------
    logic       tx_active      = 1'b0;
    logic [3:0] tx_pos         = '0;
    logic [7:0] tx_bits        = '0;
    logic       tx_par_bit     = 1'b0;
    logic [3:0] rx_pos         = '0;
    logic [7:0] rx_bits        = '0;
    logic [2:0] rx_frame       = '0;    // bit 0 start, bit 1 stop, bit 2 parity
    logic       awaiting_ack   = 1'b0;
    logic [1:0] ack_seen       = ACK_NONE;
    logic [7:0] rx_fifo [FIFO_DEPTH] = '{default: 8'h00};
    int         fifo_rd        = 0;
    int         fifo_wr        = 0;
    logic       fifo_overflow  = 1'b0;
    logic [7:0] bad_par_tally  = '0;
    logic [7:0] bad_frm_tally  = '0;
    logic       resend_pending = 1'b0;

    // Advances the shadow engine by one request and returns the result the
    // block must produce for it.
    function automatic t_result predict_response(t_request req);
        t_result res;
        res           = '0;
        res.event_res = EV_NONE;

        if (req.opcode == OP_EDGE) begin
            if (tx_active) begin
                // While sending, the edges only walk through the frame; the
                // edge after the stop bit hands the lines back.
                if (tx_pos < IDX_STOP) begin
                    tx_pos = tx_pos + 4'd1;
                end else begin
                    tx_pos            = '0;
                    tx_active         = 1'b0;
                    res.release_lines = 1'b1;
                    rx_pos            = '0;
                    rx_bits           = '0;
                    rx_frame          = '0;
                    awaiting_ack      = 1'b1;
                    res.event_res     = EV_TX_DONE;
                end
            end else if (rx_pos == IDX_START) begin
                rx_frame = {2'b00, req.data_line};
                rx_pos   = rx_pos + 4'd1;
            end else if (rx_pos <= IDX_LAST_DAT) begin
                rx_bits[3'(rx_pos - 4'd1)] = rx_bits[3'(rx_pos - 4'd1)] | req.data_line;
                rx_pos                     = rx_pos + 4'd1;
            end else if (rx_pos == IDX_PARITY) begin
                rx_frame[2] = req.data_line;
                rx_pos      = rx_pos + 4'd1;
            end else begin
                // Stop bit: the frame is complete, so judge it. A framing
                // error wins over parity, and parity over the byte itself.
                rx_frame[1] = req.data_line;
                if (rx_frame[0] != 1'b0 || rx_frame[1] != 1'b1) begin
                    bad_frm_tally = bad_frm_tally + 8'd1;
                    res.event_res = EV_FRM_ERR;
                end else if ((^rx_bits) == rx_frame[2]) begin
                    if (awaiting_ack) begin
                        ack_seen      = ACK_BAD;
                        res.event_res = EV_ACK_BAD;
                    end else begin
                        bad_par_tally     = bad_par_tally + 8'd1;
                        resend_pending    = 1'b1;
                        res.inhibit_clock = 1'b1;
                        res.event_res     = EV_PAR_ERR;
                    end
                end else if (rx_bits == ACK_BYTE) begin
                    ack_seen      = ACK_OK;
                    res.event_res = EV_ACK;
                end else if (rx_fifo[fifo_wr] != 8'h00) begin
                    fifo_overflow = 1'b1;
                end else if (rx_bits != 8'h00) begin
                    rx_fifo[fifo_wr] = rx_bits;
                    fifo_wr          = (fifo_wr + 1) % FIFO_DEPTH;
                    res.event_res    = EV_QUEUED;
                end
                rx_pos       = '0;
                rx_bits      = '0;
                rx_frame     = '0;
                awaiting_ack = 1'b0;
            end
        end else if (req.opcode == OP_TX) begin
            tx_active  = 1'b1;
            tx_pos     = '0;
            tx_bits    = req.tx_data;
            tx_par_bit = ~(^req.tx_data);
            ack_seen   = ACK_NONE;
        end

        // A pop reports the sticky flags as they stood before it clears them.
        res.overflow_flag  = fifo_overflow;
        res.resend_request = resend_pending;
        if (req.opcode == OP_POP) begin
            res.popped_byte = rx_fifo[fifo_rd];
            if (rx_fifo[fifo_rd] != 8'h00) begin
                rx_fifo[fifo_rd] = 8'h00;
                fifo_rd          = (fifo_rd + 1) % FIFO_DEPTH;
            end
            fifo_overflow  = 1'b0;
            resend_pending = 1'b0;
        end

        // The host pulls the data line low for a zero bit it is sending.
        if (!tx_active)
            res.drive_data_low = 1'b0;
        else if (tx_pos == IDX_START)
            res.drive_data_low = 1'b1;
        else if (tx_pos <= IDX_LAST_DAT)
            res.drive_data_low = ~tx_bits[3'(tx_pos - 4'd1)];
        else if (tx_pos == IDX_PARITY)
            res.drive_data_low = ~tx_par_bit;
        else
            res.drive_data_low = 1'b0;

        res.ack_status          = ack_seen;
        res.parity_error_count  = bad_par_tally;
        res.framing_error_count = bad_frm_tally;
        res.transmitting        = tx_active;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    task automatic add_request(logic [1:0] op, logic dl, logic [7:0] data);
        pending_requests.push_back('{opcode: op, data_line: dl, tx_data: data});
        items_queued++;
    endtask

    // One device frame, sent as an edge request for each of its bits. Pops may be slipped in
    // between edges, which must leave the frame undisturbed.
    task automatic add_frame(logic [7:0] data, logic parity_bad, logic start_lvl,
                             logic stop_lvl);
        logic [10:0] levels;
        levels = {stop_lvl, (~(^data)) ^ parity_bad, data, start_lvl};
        for (int k = 0; k < FRAME_EDGES; k++) begin
            if ($urandom_range(0, 99) < pop_mix)
                add_request(OP_POP, 1'($urandom), 8'($urandom));
            add_request(OP_EDGE, levels[k], 8'($urandom));
        end
    endtask

    // A complete transmit. Sometimes it is restarted part way through with a
    // new byte. The data line is sampled but ignored while sending.
    task automatic add_transmit(logic [7:0] data);
        int early;
        add_request(OP_TX, 1'($urandom), data);
        if ($urandom_range(0, 99) < 10) begin
            early = $urandom_range(0, FRAME_EDGES - 1);
            repeat (early) add_request(OP_EDGE, 1'($urandom), 8'($urandom));
            add_request(OP_TX, 1'($urandom), 8'($urandom));
        end
        repeat (FRAME_EDGES) add_request(OP_EDGE, 1'($urandom), 8'($urandom));
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] v;
        do v = 8'($urandom); while (v == 8'h00 || v == ACK_BYTE);
        return v;
    endfunction

    // Holds the sender until the block has handed over every result.
    task automatic wait_for_drain();
        while (pending_requests.size() != 0 || i_valid || expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d: %s expected 0x%0h, got 0x%0h",
                         results_seen, name, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // Clock.
    // ------------------------------------------------------------------
    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Driver. A request is taken at an edge where i_valid and o_ready are both
    // high; that request is modeled right there. A new request is put up only
    // once the old one is gone, so valid and payload hold until acceptance.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : driver
        t_request next_req;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready)
                expected_results.push_back(predict_response('{opcode: i_opcode,
                    data_line: i_data_line, tx_data: i_tx_byte}));
            if (!i_valid || o_ready) begin
                if (pending_requests.size() != 0 &&
                    $urandom_range(0, 99) >= send_idle_pct) begin
                    next_req    = pending_requests.pop_front();
                    i_valid     <= 1'b1;
                    i_opcode    <= next_req.opcode;
                    i_data_line <= next_req.data_line;
                    i_tx_byte   <= next_req.tx_data;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor. It throttles i_ready and checks every result that is taken.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_result want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= stall_pct);
            if (o_valid && i_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: no request outstanding for it", results_seen);
                end else begin
                    want = expected_results.pop_front();
                    check_field("drive_data_low", want.drive_data_low, o_drive_data_low);
                    check_field("release_lines", want.release_lines, o_release_lines);
                    check_field("inhibit_clock", want.inhibit_clock, o_inhibit_clock);
                    check_field("event_res", want.event_res, o_event_res);
                    check_field("popped_byte", want.popped_byte, o_popped_byte);
                    check_field("overflow_flag", want.overflow_flag, o_overflow_flag);
                    check_field("ack_status", want.ack_status, o_ack_status);
                    check_field("parity_error_count", want.parity_error_count,
                                o_parity_error_count);
                    check_field("framing_error_count", want.framing_error_count,
                                o_framing_error_count);
                    check_field("transmitting", want.transmitting, o_transmitting);
                    check_field("resend_request", want.resend_request, o_resend_request);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog. It counts cycles in which neither channel moves anything.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : watchdog
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
                $display("== FAIL ==");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus. Reset, a short directed part, then random phases that differ
    // in how often each side idles. The sender drains the block between
    // phases.
    // ------------------------------------------------------------------
    initial begin : stimulus
        int          send_idle_by_phase [NUM_PHASES];
        int          stall_by_phase     [NUM_PHASES];
        int          pick;
        int          kind;
        logic [7:0]  data;
        logic        par_bad;
        logic        start_lvl;
        logic        stop_lvl;

        send_idle_by_phase = '{0, 51, 0, 8, 0};
        stall_by_phase     = '{0, 0, 51, 8, 0};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part: the unused opcode with every field high, a pop of
        // the empty buffer, a frame whose data runs from all zeros to a set
        // MSB, popping it back, a transmit restarted while busy, and then
        // the full transmit of 0xFF with the release of the lines.
        add_request(OP_UNUSED, 1'b1, 8'hFF);
        add_request(OP_POP, 1'b0, 8'h00);
        add_frame(8'h80, 1'b0, 1'b0, 1'b1);
        add_request(OP_POP, 1'b1, 8'hFF);
        add_request(OP_TX, 1'b0, 8'h00);
        add_request(OP_TX, 1'b1, 8'hFF);
        repeat (FRAME_EDGES) add_request(OP_EDGE, 1'b0, 8'h00);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            send_idle_pct = send_idle_by_phase[ph];
            stall_pct     = stall_by_phase[ph];

            // In two phases, fill the buffer past its depth with no pops in
            // between, so that it overflows, and then pop it past empty.
            if (ph == 0 || ph == 3) begin
                pop_mix = 0;
                repeat (FIFO_DEPTH + 2) add_frame(plain_byte(), 1'b0, 1'b0, 1'b1);
                repeat (FIFO_DEPTH + 4) add_request(OP_POP, 1'($urandom), 8'($urandom));
            end
            pop_mix = 3;

            while (items_queued < (ph + 1) * PHASE_ITEMS + 26) begin
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    // A frame from the device: mostly good bytes, with some
                    // acknowledges, zero bytes, parity and framing errors.
                    kind = $urandom_range(0, 99);
                    if (kind < 8)
                        data = ACK_BYTE;
                    else if (kind < 12)
                        data = 8'h00;
                    else
                        data = 8'($urandom);
                    par_bad   = ($urandom_range(0, 99) < 10);
                    start_lvl = 1'b0;
                    stop_lvl  = 1'b1;
                    if ($urandom_range(0, 99) < 8) begin
                        case ($urandom_range(0, 2))
                            0:       start_lvl = 1'b1;
                            1:       stop_lvl  = 1'b0;
                            default: begin
                                start_lvl = 1'b1;
                                stop_lvl  = 1'b0;
                            end
                        endcase
                    end
                    add_frame(data, par_bad, start_lvl, stop_lvl);
                end else if (pick < 65) begin
                    // A command followed by the device's answer.
                    add_transmit(8'($urandom));
                    kind = $urandom_range(0, 99);
                    if (kind < 55)
                        add_frame(ACK_BYTE, 1'b0, 1'b0, 1'b1);
                    else if (kind < 75)
                        add_frame(ACK_BYTE, 1'b1, 1'b0, 1'b1);
                    else if (kind < 90)
                        add_frame(8'($urandom), 1'b1, 1'b0, 1'b1);
                    else
                        add_frame(8'($urandom), 1'b0, 1'b0, 1'b1);
                end else if (pick < 90) begin
                    add_request(OP_POP, 1'($urandom), 8'($urandom));
                end else if (pick < 95) begin
                    add_request(OP_UNUSED, 1'($urandom), 8'($urandom));
                end else begin
                    // Noise, then a full transmit to bring the frames back
                    // into step.
                    repeat ($urandom_range(1, 6))
                        add_request(2'($urandom), 1'($urandom), 8'($urandom));
                    add_transmit(8'($urandom));
                end
            end

            @(negedge i_clk);
            wait_for_drain();
            @(negedge i_clk);
        end

        repeat (SETTLE_WAIT) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
